### rtl/mexp_pkg.sv
// -----------------------------------------------------------------------------
// mexp_pkg: shared widths and types for the modular exponentiation unit
// Holds operand widths and the status word passed from the reduction unit.
// -----------------------------------------------------------------------------
package mexp_pkg;

   localparam int WORD_W = 32;
   localparam int PROD_W = 2 * WORD_W;
   localparam int EXP_W  = 63;
   localparam int CNT_W  = $clog2(PROD_W);

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [PROD_W-1:0] prod_type;
   typedef logic [EXP_W-1:0]  exp_type;

   // status of the reduction unit: done pulses for one cycle with a valid remainder
   typedef struct packed {
      logic     done;
      word_type remainder;
   } red_status_type;

endpackage

### rtl/modular_exponentiation_unit.sv
// -----------------------------------------------------------------------------
// modular_exponentiation_unit: base ** exponent mod m, square and multiply
// Sequencer around one registered multiplier and one shift-subtract reducer.
// -----------------------------------------------------------------------------
// Usage:
//   csr_ channel: write the modulus (csr_modulus) while the unit is idle;
//   csr_ready is always high. Reset sets the modulus to 1.
//   req_ channel: one word carries req_base and req_exponent. req_stall is
//   high while an item is in progress, so one item is worked on at a time.
//   rsp_ channel: one word per item, rsp_power_result, held in an output
//   register until taken (rsp_valid high, rsp_stall low). A new request is
//   accepted while that result still waits.
// Sequence: every modular product is a multiply step, a start step, 64
//   reducer steps and a done step, set by the bit-serial reducer; the
//   initial base reduction has no multiply step. With n exponent bits up to
//   the top set bit, an item needs popcount(exponent) + n - 1 modular
//   products after the base reduction. A zero exponent needs only the base
//   reduction and a zero modulus none. The next request is taken the cycle
//   after the result is registered.
// Reset clears the sequencer and output valid; if the receiver stalls a
// finished result, the unit holds its next result until the register frees.
// -----------------------------------------------------------------------------
module modular_exponentiation_unit (
   input  logic                      clock,
   input  logic                      reset,
   // configuration
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [31:0]               csr_modulus,
   // request
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [31:0]               req_base,
   input  logic [62:0]               req_exponent,
   // response
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [31:0]               rsp_power_result
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BASE_START,
      ST_BASE_WAIT,
      ST_CHECK,
      ST_ACC_MUL,
      ST_ACC_START,
      ST_ACC_WAIT,
      ST_SQ_MUL,
      ST_SQ_START,
      ST_SQ_WAIT,
      ST_DONE
   } state_type;

   state_type                 state_ff, state_in;
   mexp_pkg::word_type        modulus_ff, modulus_in;
   mexp_pkg::word_type        base_ff, base_in;
   mexp_pkg::word_type        acc_ff, acc_in;
   mexp_pkg::exp_type         exp_ff, exp_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   mexp_pkg::word_type        result_ff, result_in;

   mexp_pkg::word_type        mul_a;
   mexp_pkg::prod_type        product;
   logic                      red_start;
   mexp_pkg::prod_type        red_operand;
   mexp_pkg::red_status_type  red_status;
   logic                      accept;
   logic                      out_free;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // multiply the accumulator by the base, or square the base
   assign mul_a = (state_ff == ST_ACC_MUL) ? acc_ff : base_ff;

   mexp_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (base_ff),
      .product (product)
   );

   assign red_start   = (state_ff == ST_BASE_START) || (state_ff == ST_ACC_START) ||
                        (state_ff == ST_SQ_START);
   assign red_operand = (state_ff == ST_BASE_START) ?
                        {{mexp_pkg::WORD_W{1'b0}}, base_ff} : product;

   mexp_reduce u_reduce (
      .clock   (clock),
      .reset   (reset),
      .start   (red_start),
      .operand (red_operand),
      .modulus (modulus_ff),
      .status  (red_status)
   );

   always_comb begin
      state_in     = state_ff;
      modulus_in   = modulus_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      exp_in       = exp_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_valid && csr_ready) begin
         modulus_in = csr_modulus;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               base_in = req_base;
               exp_in  = req_exponent;
               // 1 mod m: zero for a modulus of one or zero
               acc_in  = (modulus_ff > mexp_pkg::word_type'(1)) ?
                         mexp_pkg::word_type'(1) : '0;
               if (modulus_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_BASE_START;
               end
            end
         end
         ST_BASE_START: begin
            state_in = ST_BASE_WAIT;
         end
         ST_BASE_WAIT: begin
            if (red_status.done) begin
               base_in  = red_status.remainder;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            priority if (exp_ff == '0) begin
               state_in = ST_DONE;
            end else if (exp_ff[0]) begin
               state_in = ST_ACC_MUL;
            end else begin
               state_in = ST_SQ_MUL;
            end
         end
         ST_ACC_MUL: begin
            state_in = ST_ACC_START;
         end
         ST_ACC_START: begin
            state_in = ST_ACC_WAIT;
         end
         ST_ACC_WAIT: begin
            if (red_status.done) begin
               acc_in = red_status.remainder;
               // skip the last squaring, nothing uses it
               if (exp_ff[mexp_pkg::EXP_W-1:1] == '0) begin
                  exp_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SQ_MUL;
               end
            end
         end
         ST_SQ_MUL: begin
            state_in = ST_SQ_START;
         end
         ST_SQ_START: begin
            state_in = ST_SQ_WAIT;
         end
         ST_SQ_WAIT: begin
            if (red_status.done) begin
               base_in  = red_status.remainder;
               exp_in   = {1'b0, exp_ff[mexp_pkg::EXP_W-1:1]};
               state_in = ST_CHECK;
            end
         end
         ST_DONE: begin
            // hold until the output register frees
            if (out_free) begin
               result_in    = acc_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         modulus_ff   <= mexp_pkg::word_type'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff   <= base_in;
      acc_ff    <= acc_in;
      exp_ff    <= exp_in;
      result_ff <= result_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = result_ff;

endmodule

### rtl/mexp_mul.sv
// -----------------------------------------------------------------------------
// mexp_mul: registered 32 x 32 multiplier
// Forms the full 64-bit unsigned product, registered, so it is available in the cycle after the operands.
// -----------------------------------------------------------------------------
module mexp_mul (
   input  logic               clock,
   input  mexp_pkg::word_type op_a,
   input  mexp_pkg::word_type op_b,
   output mexp_pkg::prod_type product
);

   mexp_pkg::prod_type product_ff;
   mexp_pkg::prod_type product_in;

   assign product_in = mexp_pkg::prod_type'(op_a) * mexp_pkg::prod_type'(op_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

### rtl/mexp_reduce.sv
// -----------------------------------------------------------------------------
// mexp_reduce: sequential shift-subtract reduction
// Reduces a 64-bit operand modulo a 32-bit modulus, one dividend bit per cycle.
// -----------------------------------------------------------------------------
module mexp_reduce (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  mexp_pkg::prod_type          operand,
   input  mexp_pkg::word_type          modulus,
   output mexp_pkg::red_status_type    status
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [mexp_pkg::CNT_W-1:0]      count_ff, count_in;
   mexp_pkg::prod_type              x_ff, x_in;
   mexp_pkg::word_type              rem_ff, rem_in;
   logic [mexp_pkg::WORD_W:0]       trial;
   logic [mexp_pkg::WORD_W:0]       diff;

   // shift in the next dividend bit, subtract the modulus when it fits
   assign trial = {rem_ff, x_ff[mexp_pkg::PROD_W-1]};
   assign diff  = trial - {1'b0, modulus};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      x_in     = x_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         x_in     = operand;
         rem_in   = '0;
      end else if (busy_ff) begin
         x_in     = {x_ff[mexp_pkg::PROD_W-2:0], 1'b0};
         rem_in   = (trial >= {1'b0, modulus}) ? diff[mexp_pkg::WORD_W-1:0]
                                               : trial[mexp_pkg::WORD_W-1:0];
         count_in = count_ff + 1'b1;
         if (count_ff == {mexp_pkg::CNT_W{1'b1}}) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      x_ff   <= x_in;
      rem_ff <= rem_in;
   end

   assign status.done      = done_ff;
   assign status.remainder = rem_ff;

endmodule

### sim/modular_exponentiation_unit_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// modular_exponentiation_unit_tb: self-checking bench for the exponentiation unit
// Drives base/exponent words under several moduli and predicts each power with
// a square-and-multiply model. Results are compared in order. Both sides
// idle and stall at random, and a cycle limit guards against a hang.
// -----------------------------------------------------------------------------
module modular_exponentiation_unit_tb;

   // expected powers for accepted requests, oldest first
   class modexp_scoreboard;
      mexp_pkg::word_type modulus;
      mexp_pkg::word_type expected_powers[$];
      int                 errors;

      function new();
         modulus = 32'd1;
         errors  = 0;
      endfunction

      // right-to-left square and multiply; every product fits in 64 bits
      function mexp_pkg::word_type modpow(mexp_pkg::word_type base,
                                          mexp_pkg::exp_type exponent);
         bit [63:0] m;
         bit [63:0] acc;
         bit [63:0] sq;
         if (modulus == '0) return '0;
         m   = {32'd0, modulus};
         acc = 64'd1;
         sq  = {32'd0, base} % m;
         for (int i = 0; i < mexp_pkg::EXP_W; i++) begin
            if (exponent[i]) acc = (acc * sq) % m;
            sq = (sq * sq) % m;
         end
         acc = acc % m;
         return acc[31:0];
      endfunction

      function void note_request(mexp_pkg::word_type base, mexp_pkg::exp_type exponent);
         expected_powers = {expected_powers, modpow(base, exponent)};
      endfunction

      function void check_result(mexp_pkg::word_type actual);
         mexp_pkg::word_type want;
         if (expected_powers.size() == 0) begin
            $display("%0t: unexpected power_result, expected none, got %h", $time, actual);
            errors++;
         end else begin
            want = expected_powers.pop_front();
            if (actual !== want) begin
               $display("%0t: power_result mismatch, expected %h, got %h",
                        $time, want, actual);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_powers.size();
      endfunction
   endclass

   // The slowest item has a full 63-bit exponent; even a run of only such items
   // stays well within this limit, so it leaves a wide margin.
   localparam int CYCLE_LIMIT   = 5_000_000;
   localparam int HOLD_CYCLES   = 6000;
   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_ITEMS   = 15;

   logic               clock;
   logic               reset;
   logic               csr_valid;
   logic               csr_ready;
   mexp_pkg::word_type csr_modulus;
   logic               req_valid;
   logic               req_stall;
   mexp_pkg::word_type req_base;
   mexp_pkg::exp_type  req_exponent;
   logic               rsp_valid;
   logic               rsp_stall;
   mexp_pkg::word_type rsp_power_result;

   modexp_scoreboard powers;
   int               cycle_count;
   int               hold_cycles;   // receiver hold-off requested by the sender side
   bit               quiet_phase;   // no random idling on either side while set

   modular_exponentiation_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_modulus      (csr_modulus),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_base         (req_base),
      .req_exponent     (req_exponent),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_power_result (rsp_power_result)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Cycle limit: a hung handshake ends the run here.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   // Response side: short random stall bursts, plus a long hold-off on request.
   // The hold-off lets the unit finish one item into its output register and
   // a second behind it, so req_stall must stay up while items keep coming.
   initial begin : response_side
      int stall_run;
      stall_run = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else if (stall_run > 0) begin
            rsp_stall <= 1'b1;
            stall_run--;
         end else if (!quiet_phase && $urandom_range(0, 99) < 2) begin
            rsp_stall <= 1'b1;
            stall_run = $urandom_range(0, 4);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Take every result word accepted at this edge and check it in order.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) powers.check_result(rsp_power_result);
   end

   // Drop the request valid and hold until every expected result has come
   // back; the unit is then idle.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (powers.pending() != 0);
   endtask

   // Write the modulus only with nothing in flight, then track it in the model.
   task automatic write_modulus(input mexp_pkg::word_type m);
      drain_results();
      csr_modulus <= m;
      csr_valid   <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      powers.modulus = m;
      csr_valid <= 1'b0;
   endtask

   // Offer one request word and hold it until accepted. An optional gap comes
   // first; valid is lowered only when a gap is taken, so a back-to-back word
   // keeps valid high through the accept edge.
   task automatic send_item(input mexp_pkg::word_type base,
                            input mexp_pkg::exp_type exponent);
      if (!quiet_phase && $urandom_range(0, 99) < 3) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_base     <= base;
      req_exponent <= exponent;
      req_valid    <= 1'b1;
      do @(posedge clock); while (req_stall);
      powers.note_request(base, exponent);
   endtask

   // Mostly short exponents to keep the run fast; a few span all 63 bits so
   // every exponent bit sees both values.
   function automatic mexp_pkg::exp_type rand_exponent(input int full_pct);
      bit [63:0] r;
      int        nbits;
      r = {$urandom, $urandom};
      if ($urandom_range(0, 99) < full_pct) return r[62:0];
      nbits = $urandom_range(0, 14);
      return r[62:0] & ((63'd1 << nbits) - 63'd1);
   endfunction

   // Spread bases over full range, small values, the edge just below m and values from m up to m+3.
   function automatic mexp_pkg::word_type rand_base(input mexp_pkg::word_type m);
      unique case ($urandom_range(0, 5))
         0:       return m - 32'd1;
         1:       return mexp_pkg::word_type'($urandom_range(0, 15));
         2:       return m + mexp_pkg::word_type'($urandom_range(0, 3));
         default: return mexp_pkg::word_type'($urandom);
      endcase
   endfunction

   function automatic mexp_pkg::word_type rand_modulus(input int phase);
      mexp_pkg::word_type m;
      unique case (phase)
         0:       m = mexp_pkg::word_type'($urandom_range(2, 1000));
         1:       m = 32'hFFFF_FFFF;
         2:       m = mexp_pkg::word_type'($urandom_range(1, 65535));
         default: m = mexp_pkg::word_type'($urandom);
      endcase
      if (m == '0) m = 32'd1;
      return m;
   endfunction

   initial begin
      mexp_pkg::word_type m;
      powers      = new();
      hold_cycles = 0;
      quiet_phase = 1'b0;
      reset        <= 1'b1;
      csr_valid    <= 1'b0;
      csr_modulus  <= '0;
      req_valid    <= 1'b0;
      req_base     <= '0;
      req_exponent <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // --- directed: modulus left at its reset value of one, every result 0
      send_item(32'd0, 63'd0);
      send_item(32'd5, 63'd0);
      send_item(32'hFFFF_FFFF, {63{1'b1}});

      // --- directed: largest modulus
      write_modulus(32'hFFFF_FFFF);
      send_item(32'd0, 63'd0);                     // zero to the zero gives one
      send_item(32'd0, 63'd5);
      send_item(32'd1, {63{1'b1}});
      send_item(32'hFFFF_FFFF, 63'd3);             // base reduces to zero
      send_item(32'hFFFF_FFFE, 63'd2);             // (m-1)^2 = 1
      send_item(32'hFFFF_FFFE, {63{1'b1}});        // odd power gives the top result
      send_item(32'd2, 63'd31);
      send_item(32'd2, 63'd32);                    // wraps back to one
      send_item(32'h1234_5678, {32'h5555_5555, 31'h5555_5555});
      send_item(32'hDEAD_BEEF, {32'h2AAA_AAAA, 31'h2AAA_AAAA});

      // --- directed: largest 32-bit prime, Fermat gives one
      write_modulus(32'hFFFF_FFFB);
      send_item(32'd3, 63'h0000_0000_FFFF_FFFA);
      send_item(32'd7, 63'd0);

      // --- directed: smallest useful modulus
      write_modulus(32'd2);
      send_item(32'd3, 63'd1);
      send_item(32'd4, 63'd1);

      // --- directed: modulus of one written explicitly
      write_modulus(32'd1);
      send_item(32'd123, 63'd7);

      // --- random phases, one modulus each
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         m = rand_modulus(phase);
         write_modulus(m);
         quiet_phase = (phase == 1);
         if (phase == 2) begin
            // long receiver hold-off while short items keep arriving
            hold_cycles = HOLD_CYCLES;
            for (int k = 0; k < 6; k++) send_item(rand_base(m), rand_exponent(0));
         end
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // pause the sender once until everything is back
            if (phase == 3 && k == PHASE_ITEMS / 2) drain_results();
            send_item(rand_base(m), rand_exponent(8));
         end
      end
      quiet_phase = 1'b0;

      drain_results();
      repeat (200) @(posedge clock);
      if (powers.errors == 0 && powers.pending() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

### modular_exponentiation_unit.f
rtl/mexp_pkg.sv
rtl/mexp_mul.sv
rtl/mexp_reduce.sv
rtl/modular_exponentiation_unit.sv
sim/modular_exponentiation_unit_tb.sv
